/* src/string_comment_lexer_unit_defines.svh */
// Assertion macros used by the lexer core (scl_core).
// Needs clk and rst_n in scope; bodies vanish when SYNTH is defined.
`ifndef STRING_COMMENT_LEXER_UNIT_DEFINES_SVH
`define STRING_COMMENT_LEXER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define SCL_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define SCL_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SCL_ASSERT_SAME(lbl, pre, post, msg)
`define SCL_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

/* src/scl_pkg.sv */
// Types, constants and the delimiter compare for the string/comment lexer.
// No dependencies; imported by every lexer module.
package scl_pkg;

    localparam int MAX_DELIM_LEN = 4;
    localparam int DELIM_BYTES   = 4;
    localparam int DELIM_W       = 35;
    localparam int CFG_ADDR_W    = 3;
    localparam int IN_DATA_W     = 64;
    localparam int OUT_DATA_W    = 72;

    // longest delimiter that may ever match
    localparam logic [2:0] DELIM_LEN_LIMIT =
        (MAX_DELIM_LEN < DELIM_BYTES) ? 3'(MAX_DELIM_LEN) : 3'(DELIM_BYTES);

    localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE  = 8'h27;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

    localparam logic [7:0] ESCAPE_RESET   = 8'd92;
    localparam logic [7:0] DQ_STYLE_RESET = 8'd1;
    localparam logic [7:0] SQ_STYLE_RESET = 8'd2;
    localparam logic [7:0] CM_STYLE_RESET = 8'd3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LINE_DELIM  = 3'd0,
        REG_BLOCK_OPEN  = 3'd1,
        REG_BLOCK_CLOSE = 3'd2,
        REG_ESCAPE      = 3'd3,
        REG_DQ_STYLE    = 3'd4,
        REG_SQ_STYLE    = 3'd5,
        REG_CM_STYLE    = 3'd6
    } reg_idx_t;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_DQ    = 5'b00010,
        MODE_SQ    = 5'b00100,
        MODE_LINE  = 5'b01000,
        MODE_BLOCK = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [DELIM_W-1:0] line_delim;
        logic [DELIM_W-1:0] block_open;
        logic [DELIM_W-1:0] block_close;
        logic [7:0]         escape_char;
        logic [7:0]         dq_style;
        logic [7:0]         sq_style;
        logic [7:0]         cm_style;
    } cfg_t;

    typedef struct packed {
        logic        chunk_start;
        logic [31:0] position;
        logic [23:0] ahead_bytes;
        logic [7:0]  text_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  run_style;
        logic [31:0] run_length;
        logic [31:0] run_start;
    } res_t;

    // length in bits 34:32, bytes first-lowest below; zero length never matches
    function automatic logic delim_match(logic [DELIM_W-1:0] d, logic [31:0] win);
        logic [2:0] n;
        logic       hit;
        n   = d[34:32];
        hit = (n != 3'd0) && (n <= DELIM_LEN_LIMIT);
        for (int i = 0; i < DELIM_BYTES; i++) begin
            if ((3'(i) < n) && (d[8*i +: 8] != win[8*i +: 8]))
            begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage

/* src/scl_cfg_regs.sv */
// Configuration register file for the lexer: delimiters, escape byte, styles.
// Depends on scl_pkg.
module scl_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [scl_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [scl_pkg::DELIM_W-1:0]    cfg_wdata,
    output scl_pkg::cfg_t                  cfg
);
    import scl_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_delim  <= '0;
            cfg_reg.block_open  <= '0;
            cfg_reg.block_close <= '0;
            cfg_reg.escape_char <= ESCAPE_RESET;
            cfg_reg.dq_style    <= DQ_STYLE_RESET;
            cfg_reg.sq_style    <= SQ_STYLE_RESET;
            cfg_reg.cm_style    <= CM_STYLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LINE_DELIM:  cfg_reg.line_delim  <= cfg_wdata;
                REG_BLOCK_OPEN:  cfg_reg.block_open  <= cfg_wdata;
                REG_BLOCK_CLOSE: cfg_reg.block_close <= cfg_wdata;
                REG_ESCAPE:      cfg_reg.escape_char <= cfg_wdata[7:0];
                REG_DQ_STYLE:    cfg_reg.dq_style    <= cfg_wdata[7:0];
                REG_SQ_STYLE:    cfg_reg.sq_style    <= cfg_wdata[7:0];
                REG_CM_STYLE:    cfg_reg.cm_style    <= cfg_wdata[7:0];
                default:         ; // unmapped index, dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/scl_in_stage.sv */
// Lexer input register: captures a byte request per cycle while empty or the held item moves on.
// Depends on scl_pkg.
module scl_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [scl_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          advance,
    output logic                          item_valid,
    output scl_pkg::item_t                item
);
    import scl_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.text_byte   <= s_tdata[7:0];
            item_reg.ahead_bytes <= s_tdata[31:8];
            item_reg.position    <= s_tdata[63:32];
            item_reg.chunk_start <= s_tuser;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* src/scl_core.sv */
// Lexer mode logic: holds mode, run start and previous byte, decides one byte
// per cycle while fire is high, forms the run result. Depends on scl_pkg and the defines header.
`include "string_comment_lexer_unit_defines.svh"

module scl_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  scl_pkg::item_t item,
    input  scl_pkg::cfg_t  cfg,
    output logic           emit,
    output scl_pkg::res_t  res
);
    import scl_pkg::*;

    mode_t       mode_reg;
    mode_t       mode_next;
    mode_t       mode_cur;
    logic [31:0] run_begin_reg;
    logic [31:0] run_begin_next;
    logic [7:0]  prior_byte_reg;

    logic [31:0] win;
    logic        escaped;
    logic [2:0]  extra;
    logic [7:0]  style;
    logic [31:0] diff;
    logic [32:0] len_sum;

    assign win     = {item.ahead_bytes, item.text_byte};
    assign escaped = (prior_byte_reg == cfg.escape_char);
    assign mode_cur = item.chunk_start ? MODE_IDLE : mode_reg;

    always_comb
    begin
        mode_next      = mode_cur;
        run_begin_next = run_begin_reg;
        emit           = 1'b0;
        extra          = 3'd1;
        style          = cfg.cm_style;
        unique case (mode_cur)
            MODE_IDLE:
            begin
                if (delim_match(cfg.line_delim, win))
                begin
                    mode_next      = MODE_LINE;
                    run_begin_next = item.position;
                end
                else if (item.text_byte == CHAR_DQUOTE)
                begin
                    mode_next      = MODE_DQ;
                    run_begin_next = item.position;
                end
                else if (item.text_byte == CHAR_SQUOTE)
                begin
                    mode_next      = MODE_SQ;
                    run_begin_next = item.position;
                end
                else if (delim_match(cfg.block_open, win))
                begin
                    mode_next      = MODE_BLOCK;
                    run_begin_next = item.position;
                end
            end
            MODE_DQ:
            begin
                style = cfg.dq_style;
                emit  = (item.text_byte == CHAR_DQUOTE) && !escaped;
            end
            MODE_SQ:
            begin
                style = cfg.sq_style;
                emit  = (item.text_byte == CHAR_SQUOTE) && !escaped;
            end
            MODE_LINE:
            begin
                emit = (item.text_byte == CHAR_NEWLINE);
            end
            MODE_BLOCK:
            begin
                extra = cfg.block_close[34:32];
                emit  = delim_match(cfg.block_close, win);
            end
            default:
            begin
                // unreachable code: behaves as a run that never closes
            end
        endcase
        if (emit)
        begin
            mode_next      = MODE_IDLE;
            run_begin_next = '0;
        end
    end

    // difference wraps first, then one byte (or the close delimiter length in block mode) is added and saturated
    assign diff    = item.position - run_begin_reg;
    assign len_sum = {1'b0, diff} + 33'(extra);

    assign res.run_start  = run_begin_reg;
    assign res.run_length = len_sum[32] ? '1 : len_sum[31:0];
    assign res.run_style  = style;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            run_begin_reg  <= '0;
            prior_byte_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            run_begin_reg  <= run_begin_next;
            prior_byte_reg <= item.text_byte;
        end
    end

    `SCL_ASSERT_NEXT(a_close_to_idle, fire && emit, (mode_reg == MODE_IDLE) && (run_begin_reg == 32'd0), "run close did not return to idle")
    `SCL_ASSERT_SAME(a_len_nonzero, fire && emit && (mode_cur != MODE_BLOCK), res.run_length != 32'd0, "zero run length")
    `SCL_ASSERT_NEXT(a_prior_tracks, fire, prior_byte_reg == $past(item.text_byte), "previous byte not tracked")

endmodule

/* src/scl_out_stage.sv */
// Result register of the lexer: holds one run until the sink takes it.
// Depends on scl_pkg.
module scl_out_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic                           emit,
    input  scl_pkg::res_t                  res,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [scl_pkg::OUT_DATA_W-1:0] m_tdata
);
    import scl_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = emit;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.run_style, res_reg.run_length, res_reg.run_start};

endmodule

/* src/string_comment_lexer_unit.sv */
// String and comment run lexer, one text byte per request.
// A run shows on m_tvalid once its closing byte has passed the input register and been fired into the output register.
// Throughput: one byte per cycle while no result is held back; the only loop is the mode/run-start register update.
// A result waiting in the output register stalls intake only while it is not taken.
// Reset (rst_n, async, low): idle mode, run start and previous byte zero, registers to defaults.
module string_comment_lexer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [scl_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [scl_pkg::DELIM_W-1:0]    cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] text_byte, [31:8] ahead_bytes, [63:32] position
    input  logic [scl_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] chunk_start
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] run_start, [63:32] run_length, [71:64] run_style
    output logic [scl_pkg::OUT_DATA_W-1:0] m_tdata
);
    import scl_pkg::*;

    cfg_t  cfg;
    item_t item;
    res_t  res;
    logic  item_valid;
    logic  emit;
    logic  fire;

    // item moves on when the result slot is empty or being drained
    assign fire = item_valid && (!m_tvalid || m_tready);

    scl_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    scl_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    scl_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .cfg   (cfg),
        .emit  (emit),
        .res   (res)
    );

    scl_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .emit     (emit),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* dv/tb_top.sv */
// Self-checking bench for string_comment_lexer_unit: streams text bytes, predicts string and
// comment runs with its own lexer model and checks every run leaving the block.
// Depends on scl_pkg and the lexer RTL only.
module tb_top;
    import scl_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [DELIM_W-1:0]    cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    string_comment_lexer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // lexer shadow state
    cfg_t        lex_cfg;
    mode_t       lex_mode;
    logic [31:0] run_begin;
    logic [7:0]  prior_byte;

    item_t       text_q[$];
    res_t        expected_runs[$];
    logic [7:0]  doc_q[$];
    item_t       offered;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    logic        rx_hold = 1'b0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic delim_hit(logic [DELIM_W-1:0] d, logic [31:0] win);
        logic [2:0]  n;
        logic [31:0] mask;
        n = d[34:32];
        if (n == 3'd0 || n > 3'd4 || int'(n) > MAX_DELIM_LEN)
            return 1'b0;
        mask = (n == 3'd4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
        return ((d[31:0] ^ win) & mask) == 32'd0;
    endfunction

    // Advances the lexer by one byte; returns 1 when a run closes.
    function automatic logic scan_byte(input item_t it, output res_t run);
        logic [31:0] win;
        logic        escaped;
        logic        hit;
        logic [31:0] extra;
        logic [7:0]  style;
        logic [32:0] span;
        win     = {it.ahead_bytes, it.text_byte};
        escaped = (prior_byte == lex_cfg.escape_char);
        hit     = 1'b0;
        extra   = 32'd1;
        style   = '0;
        run     = '0;
        if (it.chunk_start)
            lex_mode = MODE_IDLE;
        case (lex_mode)
            MODE_IDLE:
            begin
                if (delim_hit(lex_cfg.line_delim, win))
                begin
                    lex_mode  = MODE_LINE;
                    run_begin = it.position;
                end
                else if (it.text_byte == CHAR_DQUOTE)
                begin
                    lex_mode  = MODE_DQ;
                    run_begin = it.position;
                end
                else if (it.text_byte == CHAR_SQUOTE)
                begin
                    lex_mode  = MODE_SQ;
                    run_begin = it.position;
                end
                else if (delim_hit(lex_cfg.block_open, win))
                begin
                    lex_mode  = MODE_BLOCK;
                    run_begin = it.position;
                end
            end
            MODE_DQ:
            begin
                hit   = (it.text_byte == CHAR_DQUOTE) && !escaped;
                style = lex_cfg.dq_style;
            end
            MODE_SQ:
            begin
                hit   = (it.text_byte == CHAR_SQUOTE) && !escaped;
                style = lex_cfg.sq_style;
            end
            MODE_LINE:
            begin
                hit   = (it.text_byte == CHAR_NEWLINE);
                style = lex_cfg.cm_style;
            end
            MODE_BLOCK:
            begin
                hit   = delim_hit(lex_cfg.block_close, win);
                extra = 32'(lex_cfg.block_close[34:32]);
                style = lex_cfg.cm_style;
            end
            default:
            begin
            end
        endcase
        if (hit)
        begin
            // distance wraps at 32 bits, the added length saturates
            span           = {1'b0, it.position - run_begin} + {1'b0, extra};
            run.run_start  = run_begin;
            run.run_length = span[32] ? 32'hFFFF_FFFF : span[31:0];
            run.run_style  = style;
            lex_mode       = MODE_IDLE;
            run_begin      = '0;
        end
        prior_byte = it.text_byte;
        return hit;
    endfunction

    // driver
    always @(posedge clk)
    begin
        res_t run;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (scan_byte(offered, run))
                    expected_runs.push_back(run);
            end
            if (!s_tvalid || s_tready)
            begin
                if (text_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    offered = text_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= offered[IN_DATA_W-1:0];
                    s_tuser  <= offered.chunk_start;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = res_t'(m_tdata);
                if (expected_runs.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected run, expected none, got start %h len %h style %h",
                             $time, got.run_start, got.run_length, got.run_style);
                end
                else
                begin
                    want = expected_runs.pop_front();
                    if (got.run_start !== want.run_start)
                    begin
                        mismatches++;
                        $display("%0t: run_start expected %h got %h",
                                 $time, want.run_start, got.run_start);
                    end
                    if (got.run_length !== want.run_length)
                    begin
                        mismatches++;
                        $display("%0t: run_length expected %h got %h",
                                 $time, want.run_length, got.run_length);
                    end
                    if (got.run_style !== want.run_style)
                    begin
                        mismatches++;
                        $display("%0t: run_style expected %h got %h",
                                 $time, want.run_style, got.run_style);
                    end
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic load_regs(input cfg_t c);
        logic [DELIM_W-1:0] val;
        for (int i = int'(REG_LINE_DELIM); i <= int'(REG_CM_STYLE); i++)
        begin
            case (reg_idx_t'(i))
                REG_LINE_DELIM:  val = c.line_delim;
                REG_BLOCK_OPEN:  val = c.block_open;
                REG_BLOCK_CLOSE: val = c.block_close;
                REG_ESCAPE:      val = DELIM_W'(c.escape_char);
                REG_DQ_STYLE:    val = DELIM_W'(c.dq_style);
                REG_SQ_STYLE:    val = DELIM_W'(c.sq_style);
                default:         val = DELIM_W'(c.cm_style);
            endcase
            cfg_we    <= 1'b1;
            cfg_addr  <= reg_idx_t'(i);
            cfg_wdata <= val;
            @(posedge clk);
        end
        cfg_we  <= 1'b0;
        lex_cfg = c;
    endtask

    // waits until every request is taken and every run has come back
    task automatic settle();
        while (text_q.size() != 0 || s_tvalid || expected_runs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic [23:0] ahead,
                            input logic [31:0] pos, input logic cs);
        item_t it;
        it.text_byte   = b;
        it.ahead_bytes = ahead;
        it.position    = pos;
        it.chunk_start = cs;
        text_q.push_back(it);
    endtask

    function automatic logic [7:0] letter();
        return 8'($urandom_range(8'h7A, 8'h61));
    endfunction

    // bytes the lexer reacts to, plus anything at all
    function automatic logic [7:0] any_byte();
        case ($urandom_range(7))
            0:       return CHAR_DQUOTE;
            1:       return CHAR_SQUOTE;
            2:       return CHAR_NEWLINE;
            3:       return lex_cfg.escape_char;
            4:       return lex_cfg.line_delim[7:0];
            5:       return lex_cfg.block_close[7:0];
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] peek(int j);
        return (j < doc_q.size()) ? doc_q[j] : 8'h00;
    endfunction

    function automatic logic [DELIM_W-1:0] rand_delim();
        logic [31:0] bytes;
        logic [2:0]  n;
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(3))
                0:       bytes[8*i +: 8] = 8'h2F;
                1:       bytes[8*i +: 8] = 8'h2A;
                2:       bytes[8*i +: 8] = 8'h23;
                default: bytes[8*i +: 8] = 8'h61;
            endcase
        end
        n = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2, 1));
        return {n, bytes};
    endfunction

    task automatic add_delim(input logic [DELIM_W-1:0] d);
        for (int i = 0; i < 4 && i < int'(d[34:32]); i++)
            doc_q.push_back(d[8*i +: 8]);
    endtask

    task automatic add_body(input int unsigned n, input logic [7:0] quote);
        repeat (n)
        begin
            case ($urandom_range(7))
                0:
                begin
                    doc_q.push_back(lex_cfg.escape_char);
                    doc_q.push_back(quote);
                end
                1:       doc_q.push_back(any_byte());
                default: doc_q.push_back(letter());
            endcase
        end
    endtask

    task automatic add_token();
        int unsigned n;
        n = $urandom_range(8, 1);
        case ($urandom_range(9))
            0, 1:
            begin
                repeat (n) doc_q.push_back(letter());
            end
            2, 3:
            begin
                doc_q.push_back(CHAR_DQUOTE);
                add_body(n, CHAR_DQUOTE);
                if ($urandom_range(9) != 0)
                    doc_q.push_back(CHAR_DQUOTE);
            end
            4:
            begin
                doc_q.push_back(CHAR_SQUOTE);
                add_body(n, CHAR_SQUOTE);
                if ($urandom_range(9) != 0)
                    doc_q.push_back(CHAR_SQUOTE);
            end
            5, 6:
            begin
                add_delim(lex_cfg.line_delim);
                add_body(n, CHAR_DQUOTE);
                doc_q.push_back(CHAR_NEWLINE);
            end
            7:
            begin
                add_delim(lex_cfg.block_open);
                add_body(n, CHAR_SQUOTE);
                add_delim(lex_cfg.block_close);
            end
            8:
            begin
                doc_q.push_back(($urandom_range(1) != 0) ? CHAR_NEWLINE : 8'h20);
            end
            default:
            begin
                repeat (n) doc_q.push_back(any_byte());
            end
        endcase
    endtask

    // Builds chunks of well-formed text with some noise until n_items bytes are queued, byte by byte.
    task automatic queue_text(input int unsigned n_items);
        item_t       it;
        logic [31:0] pos;
        int unsigned done;
        done = 0;
        while (done < n_items)
        begin
            doc_q.delete();
            while (doc_q.size() < $urandom_range(64, 12))
                add_token();
            pos = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(40) : $urandom;
            for (int i = 0; i < doc_q.size(); i++)
            begin
                it.text_byte   = doc_q[i];
                it.ahead_bytes = {peek(i + 3), peek(i + 2), peek(i + 1)};
                it.position    = pos;
                it.chunk_start = (i == 0) || ($urandom_range(49) == 0);
                if ($urandom_range(39) == 0)
                    it.position = $urandom;
                if ($urandom_range(59) == 0)
                    it.ahead_bytes = 24'($urandom);
                text_q.push_back(it);
                pos = it.position + 32'd1;
            end
            done += doc_q.size();
        end
    endtask

    initial
    begin
        lex_cfg = '{line_delim: '0, block_open: '0, block_close: '0,
                    escape_char: ESCAPE_RESET, dq_style: DQ_STYLE_RESET,
                    sq_style: SQ_STYLE_RESET, cm_style: CM_STYLE_RESET};
        lex_mode   = MODE_IDLE;
        run_begin  = '0;
        prior_byte = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: delimiters off, only quotes open runs
        queue_text(60);
        settle();

        load_regs('{line_delim: {3'd2, 32'h0000_2F2F}, block_open: {3'd2, 32'h0000_2A2F},
                    block_close: {3'd2, 32'h0000_2F2A}, escape_char: 8'h5C,
                    dq_style: 8'h11, sq_style: 8'h22, cm_style: 8'h33});
        // escaped quote inside a string
        add_byte(CHAR_DQUOTE, 24'h00_5C_61, 32'd0, 1'b1);
        add_byte(8'h61, 24'h22_22_5C, 32'd1, 1'b0);
        add_byte(8'h5C, 24'h27_22_22, 32'd2, 1'b0);
        add_byte(CHAR_DQUOTE, 24'h5C_27_22, 32'd3, 1'b0);
        add_byte(CHAR_DQUOTE, 24'h00_00_00, 32'd4, 1'b0);
        // escaped escape is not seen: the first quote still counts as escaped
        add_byte(CHAR_SQUOTE, 24'h27_5C_5C, 32'd5, 1'b0);
        add_byte(8'h5C, 24'h27_27_5C, 32'd6, 1'b0);
        add_byte(8'h5C, 24'h00_27_27, 32'd7, 1'b0);
        add_byte(CHAR_SQUOTE, 24'h00_00_27, 32'd8, 1'b0);
        add_byte(CHAR_SQUOTE, 24'h00_00_00, 32'd9, 1'b0);
        // line comment
        add_byte(8'h2F, 24'h00_0A_2F, 32'd10, 1'b0);
        add_byte(8'h2F, 24'h00_00_0A, 32'd11, 1'b0);
        add_byte(CHAR_NEWLINE, 24'h00_00_00, 32'd12, 1'b0);
        // close marker while idle does nothing
        add_byte(8'h2A, 24'h00_00_2F, 32'd13, 1'b0);
        // "/*/" closes on the byte right after the opener
        add_byte(8'h2F, 24'h00_2F_2A, 32'd14, 1'b0);
        add_byte(8'h2A, 24'h00_00_2F, 32'd15, 1'b0);
        // open string cut off by a new chunk
        add_byte(CHAR_DQUOTE, 24'h00_00_00, 32'd100, 1'b1);
        add_byte(8'h78, 24'h00_00_00, 32'd200, 1'b1);
        // position stepping back: length saturates
        add_byte(CHAR_DQUOTE, 24'h00_00_00, 32'hFFFF_FFF0, 1'b0);
        add_byte(CHAR_DQUOTE, 24'h00_00_00, 32'hFFFF_FFEF, 1'b0);
        add_byte(8'h2F, 24'h00_00_2A, 32'd50, 1'b0);
        add_byte(8'h2A, 24'h00_00_2F, 32'd49, 1'b0);
        add_byte(8'hFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_byte(8'h00, 24'h00_0000, 32'h0000_0000, 1'b0);
        settle();

        tx_idle_pct = 87;
        queue_text(200);
        settle();

        // long delimiters, one of them past the length limit
        load_regs('{line_delim: {3'd7, 32'hFFFF_FFFF}, block_open: {3'd4, 32'h2D2D_213C},
                    block_close: {3'd3, 32'h003E_2D2D}, escape_char: 8'h00,
                    dq_style: 8'hFF, sq_style: 8'h00, cm_style: 8'hFF});
        tx_idle_pct  = 0;
        rx_stall_pct = 87;
        queue_text(150);
        settle();

        // receiver holds off while the sender keeps offering
        load_regs('{line_delim: {3'd1, 32'h0000_0023}, block_open: {3'd0, 32'hFFFF_FFFF},
                    block_close: {3'd5, 32'h0000_2F2A}, escape_char: 8'hFF,
                    dq_style: 8'h80, sq_style: 8'h7F, cm_style: 8'h01});
        rx_stall_pct = 0;
        queue_text(250);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (300) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        settle();

        // line comment opened by a double quote; a single quote opens a string ahead of the block opener
        load_regs('{line_delim: {3'd1, 32'h0000_0022}, block_open: {3'd1, 32'h0000_0027},
                    block_close: {3'd1, 32'h0000_0027}, escape_char: 8'h27,
                    dq_style: 8'h5A, sq_style: 8'hA5, cm_style: 8'h0F});
        tx_idle_pct  = 7;
        rx_stall_pct = 7;
        queue_text(90);
        settle();
        queue_text(90);
        settle();

        load_regs('{line_delim: rand_delim(), block_open: rand_delim(),
                    block_close: rand_delim(), escape_char: any_byte(),
                    dq_style: 8'($urandom), sq_style: 8'($urandom), cm_style: 8'($urandom)});
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        queue_text(100);
        settle();
        tx_idle_pct  = 87;
        rx_stall_pct = 87;
        queue_text(80);
        settle();

        load_regs('{line_delim: {3'd2, 32'h0000_2F2F}, block_open: {3'd2, 32'h0000_2A2F},
                    block_close: {3'd2, 32'h0000_2F2A}, escape_char: 8'h5C,
                    dq_style: DQ_STYLE_RESET, sq_style: SQ_STYLE_RESET, cm_style: CM_STYLE_RESET});
        tx_idle_pct  = 30;
        rx_stall_pct = 30;
        queue_text(100);
        settle();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* string_comment_lexer_unit.f */
+incdir+src
src/scl_pkg.sv
src/scl_cfg_regs.sv
src/scl_in_stage.sv
src/scl_core.sv
src/scl_out_stage.sv
src/string_comment_lexer_unit.sv
dv/tb_top.sv
